>>> rtl/periodic_task_scheduler_watchdog_core_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_WATCHDOG_CORE_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_WATCHDOG_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define PTSW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is active.
`define PTSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

>>> rtl/ptsw_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Operation codes, sequencer states and task-entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsw_pkg;

    localparam logic [2:0] OP_RUN     = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_ENABLE  = 3'd2;
    localparam logic [2:0] OP_DISABLE = 3'd3;
    localparam logic [2:0] OP_PERIOD  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_PASS   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] deadline;
        logic [31:0] last_run;
    } entry_t;

    typedef struct packed {
        logic period;
        logic deadline;
        logic last_run;
    } wmask_t;

    typedef struct packed {
        logic        due;
        logic        late;
        logic        waiting;
        logic [31:0] rem;
    } eval_t;

endpackage

`default_nettype wire

>>> rtl/ptsw_mem.sv
// ----------------------------------------------------------------------------
// Task table memory
// One write port with per-field enables, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsw_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire ptsw_pkg::wmask_t wr_mask,
    input  wire ptsw_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output ptsw_pkg::entry_t     rd_data
);

    ptsw_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_mask.period)
            begin
                mem[wr_addr].period <= wr_data.period;
            end
            if (wr_mask.deadline)
            begin
                mem[wr_addr].deadline <= wr_data.deadline;
            end
            if (wr_mask.last_run)
            begin
                mem[wr_addr].last_run <= wr_data.last_run;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ptsw_eval.sv
// ----------------------------------------------------------------------------
// Task entry evaluator
// Decides whether one task is due, late against its deadline, and its wait.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsw_eval (
    input  wire ptsw_pkg::entry_t entry,
    input  wire logic [31:0]      now,
    input  wire logic             enabled,
    output ptsw_pkg::eval_t       result
);

    logic [31:0] elapsed;
    logic        reached;

    assign elapsed = now - entry.last_run;
    assign reached = (elapsed >= entry.period);

    // A due task is stamped with now, so it is not reported late in the same pass.
    always_comb
    begin
        result.due     = enabled && reached;
        result.waiting = enabled && !reached;
        result.late    = enabled && !reached && (entry.deadline != 32'd0)
                         && (elapsed >= entry.deadline);
        result.rem     = entry.period - elapsed;
    end

endmodule

`default_nettype wire

>>> rtl/periodic_task_scheduler_watchdog_core.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler with watchdog check
// Task table in memory; run passes walk the table one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command item: run pass,
//   add task, enable, disable or set period. Output channel (out_valid /
//   out_stall) returns exactly one result item per command.
//   A table command goes to ST_FINISH on acceptance and returns its item once
//   the output register is free. A run pass reads the tasks added so far, one
//   table entry per cycle, through the memory's single read port in ST_PASS,
//   then returns its item from ST_FINISH; with an empty table it goes straight
//   to ST_FINISH. One command is in work at a time; the next one is accepted
//   in the cycle after the result is registered.
//   in_stall is high while a command is in work.
//   A stalled result stays in the output register; a finished command waits
//   for that register to free up before it lets the next command in.
//   Reset clears the task count and all enable flags; no memory clearing
//   pass is needed, as only entries written by an add are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_scheduler_watchdog_core_defines.svh"

module periodic_task_scheduler_watchdog_core #(
    parameter int TASKS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [31:0] now,
    input  wire logic [2:0]  task_index,
    input  wire logic [31:0] task_period,
    input  wire logic [31:0] deadline_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic [2:0]       added_index,
    output logic [7:0]       due_mask,
    output logic             healthy,
    output logic             idle,
    output logic [31:0]      next_wait
);

    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = $clog2(TASKS + 1);

    ptsw_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [TASKS-1:0] enabled_reg, enabled_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    ev_ptr_reg, ev_ptr_next;
    logic             ev_valid_reg, ev_valid_next;
    logic             out_valid_reg, out_valid_next;

    logic [31:0] now_reg, now_next;
    logic        res_ok_reg, res_ok_next;
    logic [2:0]  res_added_reg, res_added_next;
    logic [7:0]  res_due_reg, res_due_next;
    logic        res_healthy_reg, res_healthy_next;
    logic        res_idle_reg, res_idle_next;
    logic [31:0] res_wait_reg, res_wait_next;

    logic             ok_reg, ok_next;
    logic [2:0]       added_reg, added_next;
    logic [7:0]       due_reg, due_next;
    logic             healthy_reg, healthy_next;
    logic             idle_reg, idle_next;
    logic [31:0]      wait_reg, wait_next;

    logic             in_accept;
    logic             idx_used;
    logic [IW-1:0]    idx_addr;
    logic             ev_last;
    logic             mem_wr_en;
    logic [IW-1:0]    mem_wr_addr;
    ptsw_pkg::wmask_t mem_wr_mask;
    ptsw_pkg::entry_t mem_wr_data;
    logic             mem_rd_en;
    ptsw_pkg::entry_t mem_rd_data;
    ptsw_pkg::eval_t  ev;

    ptsw_mem #(
        .DEPTH (TASKS),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_mask (mem_wr_mask),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_ptr_reg[IW-1:0]),
        .rd_data (mem_rd_data)
    );

    ptsw_eval u_eval (
        .entry   (mem_rd_data),
        .now     (now_reg),
        .enabled (enabled_reg[ev_ptr_reg[IW-1:0]]),
        .result  (ev)
    );

    assign in_stall  = (state_reg != ptsw_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign idx_used  = (32'(task_index) < 32'(count_reg));
    assign idx_addr  = IW'(task_index);
    assign mem_rd_en = (state_reg == ptsw_pkg::ST_PASS) && (rd_ptr_reg < count_reg);
    assign ev_last   = (CW'(ev_ptr_reg + CW'(1)) == count_reg);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        enabled_next     = enabled_reg;
        rd_ptr_next      = rd_ptr_reg;
        ev_ptr_next      = ev_ptr_reg;
        ev_valid_next    = 1'b0;
        out_valid_next   = out_valid_reg;
        now_next         = now_reg;
        res_ok_next      = res_ok_reg;
        res_added_next   = res_added_reg;
        res_due_next     = res_due_reg;
        res_healthy_next = res_healthy_reg;
        res_idle_next    = res_idle_reg;
        res_wait_next    = res_wait_reg;
        ok_next          = ok_reg;
        added_next       = added_reg;
        due_next         = due_reg;
        healthy_next     = healthy_reg;
        idle_next        = idle_reg;
        wait_next        = wait_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = idx_addr;
        mem_wr_mask      = '0;
        mem_wr_data      = '{period: task_period, deadline: deadline_ms, last_run: now};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ptsw_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    now_next         = now;
                    res_ok_next      = 1'b0;
                    res_added_next   = 3'd0;
                    res_due_next     = 8'd0;
                    res_healthy_next = 1'b0;
                    res_idle_next    = 1'b0;
                    res_wait_next    = 32'd0;
                    state_next       = ptsw_pkg::ST_FINISH;
                    case (operation)
                        ptsw_pkg::OP_RUN:
                        begin
                            res_ok_next      = 1'b1;
                            res_healthy_next = 1'b1;
                            res_idle_next    = 1'b1;
                            res_wait_next    = '1;
                            rd_ptr_next      = '0;
                            if (count_reg != '0)
                            begin
                                state_next = ptsw_pkg::ST_PASS;
                            end
                        end
                        ptsw_pkg::OP_ADD:
                        begin
                            if (count_reg < CW'(TASKS))
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[IW-1:0];
                                mem_wr_mask = '{period: 1'b1, deadline: 1'b1, last_run: 1'b1};
                                enabled_next[count_reg[IW-1:0]] = 1'b1;
                                count_next     = CW'(count_reg + CW'(1));
                                res_added_next = 3'(count_reg);
                                res_ok_next    = 1'b1;
                            end
                        end
                        ptsw_pkg::OP_ENABLE:
                        begin
                            if (idx_used)
                            begin
                                // Restart timing at now.
                                mem_wr_en              = 1'b1;
                                mem_wr_mask.last_run   = 1'b1;
                                enabled_next[idx_addr] = 1'b1;
                                res_ok_next            = 1'b1;
                            end
                        end
                        ptsw_pkg::OP_DISABLE:
                        begin
                            if (idx_used)
                            begin
                                enabled_next[idx_addr] = 1'b0;
                                res_ok_next            = 1'b1;
                            end
                        end
                        ptsw_pkg::OP_PERIOD:
                        begin
                            if (idx_used)
                            begin
                                mem_wr_en          = 1'b1;
                                mem_wr_mask.period = 1'b1;
                                res_ok_next        = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ptsw_pkg::ST_PASS:
            begin
                // Issue the next read while the previous entry is evaluated.
                if (mem_rd_en)
                begin
                    rd_ptr_next   = CW'(rd_ptr_reg + CW'(1));
                    ev_ptr_next   = rd_ptr_reg;
                    ev_valid_next = 1'b1;
                end
                if (ev_valid_reg)
                begin
                    if (ev.due)
                    begin
                        mem_wr_en            = 1'b1;
                        mem_wr_addr          = ev_ptr_reg[IW-1:0];
                        mem_wr_mask.last_run = 1'b1;
                        mem_wr_data.last_run = now_reg;
                        res_due_next         = res_due_reg | (8'd1 << ev_ptr_reg);
                        res_idle_next        = 1'b0;
                    end
                    if (ev.late)
                    begin
                        res_healthy_next = 1'b0;
                    end
                    if (ev.waiting && (ev.rem < res_wait_reg))
                    begin
                        res_wait_next = ev.rem;
                    end
                    if (ev_last)
                    begin
                        state_next = ptsw_pkg::ST_FINISH;
                    end
                end
            end

            ptsw_pkg::ST_FINISH:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    added_next     = res_added_reg;
                    due_next       = res_due_reg;
                    healthy_next   = res_healthy_reg;
                    idle_next      = res_idle_reg;
                    wait_next      = res_wait_reg;
                    state_next     = ptsw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ptsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptsw_pkg::ST_IDLE;
            count_reg     <= '0;
            enabled_reg   <= '0;
            rd_ptr_reg    <= '0;
            ev_ptr_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            enabled_reg   <= enabled_next;
            rd_ptr_reg    <= rd_ptr_next;
            ev_ptr_reg    <= ev_ptr_next;
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        res_ok_reg      <= res_ok_next;
        res_added_reg   <= res_added_next;
        res_due_reg     <= res_due_next;
        res_healthy_reg <= res_healthy_next;
        res_idle_reg    <= res_idle_next;
        res_wait_reg    <= res_wait_next;
        ok_reg          <= ok_next;
        added_reg       <= added_next;
        due_reg         <= due_next;
        healthy_reg     <= healthy_next;
        idle_reg        <= idle_next;
        wait_reg        <= wait_next;
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign added_index = added_reg;
    assign due_mask    = due_reg;
    assign healthy     = healthy_reg;
    assign idle        = idle_reg;
    assign next_wait   = wait_reg;

    `PTSW_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= 32'(TASKS))
    `PTSW_ASSERT_SAME(a_eval_in_table, clk, rst_n,
        (state_reg == ptsw_pkg::ST_PASS) && ev_valid_reg, ev_ptr_reg < count_reg)
    `PTSW_ASSERT_NEXT(a_finish_delivers, clk, rst_n,
        (state_reg == ptsw_pkg::ST_FINISH) && (!out_valid_reg || !out_stall),
        out_valid_reg && (state_reg == ptsw_pkg::ST_IDLE))
    `PTSW_ASSERT_SAME(a_due_not_idle, clk, rst_n, out_valid_reg, !(idle_reg && (due_reg != 8'd0)))

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Scheduler core testbench
// Drives table and run-pass commands through the valid/stall input channel,
// predicts every result item from a local copy of the task table, and checks
// each accepted result field by field under random idling and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          NUM_SLOTS      = 8;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [2:0]  OP_RESERVED_LO = ptsw_pkg::OP_PERIOD + 3'd1;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        ok;
        logic [2:0]  added_index;
        logic [7:0]  due_mask;
        logic        healthy;
        logic        idle;
        logic [31:0] next_wait;
    } sched_result_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [2:0]  operation   = ptsw_pkg::OP_RUN;
    logic [31:0] now         = '0;
    logic [2:0]  task_index  = '0;
    logic [31:0] task_period = '0;
    logic [31:0] deadline_ms = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        ok;
    logic [2:0]  added_index;
    logic [7:0]  due_mask;
    logic        healthy;
    logic        idle;
    logic [31:0] next_wait;

    // local copy of the task table
    int unsigned tbl_count;
    logic [31:0] tbl_period   [NUM_SLOTS];
    logic [31:0] tbl_deadline [NUM_SLOTS];
    logic [31:0] tbl_last_run [NUM_SLOTS];
    logic        tbl_enabled  [NUM_SLOTS];

    sched_result_t pending_results[$];
    sched_result_t oldest_result;

    int          error_count    = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 20;
    int          recv_stall_pct = 20;
    int          stall_run      = 0;
    int          hold_cycles    = 0;
    logic [31:0] clock_ms       = '0;

    periodic_task_scheduler_watchdog_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .now         (now),
        .task_index  (task_index),
        .task_period (task_period),
        .deadline_ms (deadline_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .added_index (added_index),
        .due_mask    (due_mask),
        .healthy     (healthy),
        .idle        (idle),
        .next_wait   (next_wait)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic sched_result_t schedule_result(input logic [2:0]  op,
                                                      input logic [31:0] t,
                                                      input logic [2:0]  idx,
                                                      input logic [31:0] per,
                                                      input logic [31:0] dl);
        sched_result_t res;
        logic [31:0]   elapsed;
        logic [31:0]   rem;
        logic          ran;
        res = '0;
        ran = 1'b0;
        if (op == ptsw_pkg::OP_RUN)
        begin
            res.next_wait = ALL_ONES;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_enabled[i])
                begin
                    elapsed = t - tbl_last_run[i];
                    if (elapsed >= tbl_period[i])
                    begin
                        tbl_last_run[i] = t;
                        ran             = 1'b1;
                        res.due_mask[i] = 1'b1;
                    end
                    else
                    begin
                        rem = tbl_period[i] - elapsed;
                        if (rem < res.next_wait)
                            res.next_wait = rem;
                    end
                end
            end
            res.healthy = 1'b1;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_enabled[i] && tbl_deadline[i] != '0
                    && (t - tbl_last_run[i]) >= tbl_deadline[i])
                    res.healthy = 1'b0;
            end
            res.idle = ~ran;
            res.ok   = 1'b1;
        end
        else if (op == ptsw_pkg::OP_ADD)
        begin
            if (tbl_count < NUM_SLOTS)
            begin
                tbl_period[tbl_count]   = per;
                tbl_deadline[tbl_count] = dl;
                tbl_last_run[tbl_count] = t;
                tbl_enabled[tbl_count]  = 1'b1;
                res.added_index         = tbl_count[2:0];
                res.ok                  = 1'b1;
                tbl_count++;
            end
        end
        else if (op == ptsw_pkg::OP_ENABLE || op == ptsw_pkg::OP_DISABLE
                 || op == ptsw_pkg::OP_PERIOD)
        begin
            if (idx < tbl_count)
            begin
                if (op == ptsw_pkg::OP_ENABLE)
                begin
                    tbl_last_run[idx] = t;
                    tbl_enabled[idx]  = 1'b1;
                end
                else if (op == ptsw_pkg::OP_DISABLE)
                    tbl_enabled[idx] = 1'b0;
                else
                    tbl_period[idx] = per;
                res.ok = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= send_idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 30);
        if (r < 85)
            return $urandom_range(31, 200);
        if (r < 95)
            return $urandom;
        return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
    endfunction

    function automatic logic [31:0] pick_advance();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 12);
        if (r < 90)
            return $urandom_range(13, 60);
        if (r < 98)
            return $urandom_range(61, 5000);
        return $urandom;
    endfunction

    // Call at a rising edge; returns at the edge that accepted the item.
    task automatic send_cmd(input logic [2:0]  op,
                            input logic [31:0] t,
                            input logic [2:0]  idx,
                            input logic [31:0] per,
                            input logic [31:0] dl);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        now         <= t;
        task_index  <= idx;
        task_period <= per;
        deadline_ms <= dl;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(schedule_result(op, t, idx, per, dl));
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // result checker and output stall generator
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item arrived with no expectation pending");
                    error_count++;
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    check_field("ok", 32'(oldest_result.ok), 32'(ok));
                    check_field("added_index", 32'(oldest_result.added_index),
                                32'(added_index));
                    check_field("due_mask", 32'(oldest_result.due_mask), 32'(due_mask));
                    check_field("healthy", 32'(oldest_result.healthy), 32'(healthy));
                    check_field("idle", 32'(oldest_result.idle), 32'(idle));
                    check_field("next_wait", oldest_result.next_wait, next_wait);
                end
            end
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_run > 0)
            begin
                out_stall <= 1'b1;
                stall_run--;
            end
            else if ($urandom_range(0, 99) < recv_stall_pct)
            begin
                out_stall <= 1'b1;
                stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // commands against an empty table; only the run pass succeeds
    task automatic test_empty_table();
        send_cmd(ptsw_pkg::OP_RUN, '0, 3'd7, ALL_ONES, ALL_ONES);
        send_cmd(ptsw_pkg::OP_ENABLE, 32'd10, 3'd0, '0, '0);
        send_cmd(ptsw_pkg::OP_DISABLE, 32'd11, 3'd7, '0, '0);
        send_cmd(ptsw_pkg::OP_PERIOD, 32'd12, 3'd2, ALL_ONES, '0);
        for (int k = 0; k < 3; k++)
            send_cmd(OP_RESERVED_LO + 3'(k), ALL_ONES, 3'(k), ALL_ONES, ALL_ONES);
    endtask

    task automatic test_fill_table();
        clock_ms = 32'd1000;
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, '0, '0);             // due on every pass
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, 32'd10, 32'd15);
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, ALL_ONES, ALL_ONES);
        send_cmd(ptsw_pkg::OP_PERIOD, clock_ms, 3'd3, 32'd9, '0);       // slot not yet used
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, 32'd5, 32'd1);
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, 32'd100, '0);
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, 32'd1, 32'd3);
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, 32'd20, 32'd40);
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, 32'd7, 32'd8);
        send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'd0, 32'd3, 32'd3);       // table full
    endtask

    task automatic test_run_passes();
        send_cmd(ptsw_pkg::OP_RUN, 32'd1000, 3'd0, '0, '0);
        send_cmd(ptsw_pkg::OP_RUN, 32'd1012, 3'd0, '0, '0);
        send_cmd(ptsw_pkg::OP_DISABLE, 32'd1015, 3'd3, '0, '0);
        send_cmd(ptsw_pkg::OP_RUN, 32'd1020, 3'd0, '0, '0);
        send_cmd(ptsw_pkg::OP_PERIOD, 32'd1025, 3'd4, '0, '0);
        send_cmd(ptsw_pkg::OP_ENABLE, 32'd1030, 3'd3, '0, '0);
        send_cmd(ptsw_pkg::OP_RUN, 32'd1031, 3'd0, '0, '0);
        send_cmd(ptsw_pkg::OP_RUN, 32'hFFFF_FFF0, 3'd0, '0, '0);
        send_cmd(ptsw_pkg::OP_RUN, 32'd5, 3'd0, '0, '0);                // time wraps
        clock_ms = 32'd5;
    endtask

    // hold the output long enough that the core stalls its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_cycles   = 200;
        for (int k = 0; k < 12; k++)
        begin
            clock_ms += pick_advance();
            send_cmd(ptsw_pkg::OP_RUN, clock_ms, 3'($urandom), $urandom, $urandom);
        end
    endtask

    task automatic send_random_cmd();
        int unsigned r;
        logic [31:0] t;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            clock_ms += pick_advance();
            t = ($urandom_range(0, 99) < 3) ? $urandom : clock_ms;
            send_cmd(ptsw_pkg::OP_RUN, t, 3'($urandom), $urandom, $urandom);
        end
        else if (r < 67)
            send_cmd(ptsw_pkg::OP_ENABLE, clock_ms, 3'($urandom), $urandom, $urandom);
        else if (r < 77)
            send_cmd(ptsw_pkg::OP_DISABLE, clock_ms, 3'($urandom), $urandom, $urandom);
        else if (r < 92)
            send_cmd(ptsw_pkg::OP_PERIOD, clock_ms, 3'($urandom), pick_period(), $urandom);
        else if (r < 96)
            send_cmd(ptsw_pkg::OP_ADD, clock_ms, 3'($urandom), $urandom, $urandom);
        else
            send_cmd(OP_RESERVED_LO + 3'($urandom_range(0, 2)), $urandom,
                     3'($urandom), $urandom, $urandom);
    endtask

    task automatic test_random_mix(input int num_items);
        int style;
        for (int n = 0; n < num_items; n++)
        begin
            // change idling style every 50 items; style 0 runs back to back
            if (n % 50 == 0)
            begin
                style = $urandom_range(0, 3);
                case (style)
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 15;
                    2:       send_idle_pct = 40;
                    default: send_idle_pct = 70;
                endcase
                style = (n == 0) ? 0 : $urandom_range(0, 3);
                case (style)
                    0:       recv_stall_pct = 0;
                    1:       recv_stall_pct = 15;
                    2:       recv_stall_pct = 40;
                    default: recv_stall_pct = 70;
                endcase
            end
            send_random_cmd();
        end
    endtask

    // pause the sender until every pending result has come back
    task automatic test_drain_pause();
        for (int k = 0; k < 5; k++)
            send_random_cmd();
        wait_all_results();
        repeat ($urandom_range(1, 10)) @(posedge clk);
        for (int k = 0; k < 5; k++)
            send_random_cmd();
    endtask

    initial
    begin
        tbl_count = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_period[i]   = '0;
            tbl_deadline[i] = '0;
            tbl_last_run[i] = '0;
            tbl_enabled[i]  = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_fill_table();
        test_run_passes();
        test_backpressure();
        test_random_mix(500);
        test_drain_pause();
        test_random_mix(500);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/ptsw_pkg.sv
rtl/ptsw_mem.sv
rtl/ptsw_eval.sv
rtl/periodic_task_scheduler_watchdog_core.sv
verif/testbench.sv
